// ----- src/heading_to_differential_drive_defines.svh -----
// Assertion macros shared by the heading-to-differential-drive RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef HEADING_TO_DIFFERENTIAL_DRIVE_DEFINES_SVH
`define HEADING_TO_DIFFERENTIAL_DRIVE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define HDD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/hdd_pkg.sv -----
// Types, constants and the cosine table for the heading-to-differential-drive block.
// No dependencies; imported by the channel interfaces and the top level.
package hdd_pkg;

  localparam int SPEED_W    = 15;   // clamped speed and duty magnitude
  localparam int HEADING_W  = 9;    // heading reduced to 0..359
  localparam int COS_IDX_W  = 7;    // table index 0..90
  localparam int COS_W      = 16;   // Q1.15 entry, 1.0 needs bit 15

  localparam int COS_TABLE_BITS = 15;
  localparam int SPEED_LIMIT    = 32767;
  localparam int PERCENT_FULL   = 100;

  localparam int DEG_FULL     = 360;
  localparam int DEG_HALF     = 180;
  localparam int DEG_QUARTER  = 90;
  localparam int DEG_3QUARTER = 270;

  // Heading reduction: offset by 92 turns to stay non-negative, then divide
  // by 360 through a floor reciprocal of 2^25/360.
  localparam int HDG_EXT_W   = 17;
  localparam int HDG_OFFSET  = 92 * DEG_FULL;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP       = (1 << RECIP_SHIFT) / DEG_FULL;
  localparam int QUO_W       = 8;
  localparam int REM_W       = 10;

  typedef logic signed [15:0]    speed_in_t;
  typedef logic signed [15:0]    heading_in_t;
  typedef logic [SPEED_W-1:0]    duty_t;
  typedef logic [HEADING_W-1:0]  heading_t;

  typedef enum logic [1:0] {
    QUAD_FWD_RIGHT,   // 0..89
    QUAD_REV_RIGHT,   // 90..179
    QUAD_REV_LEFT,    // 180..269
    QUAD_FWD_LEFT     // 270..359
  } quad_t;

  typedef struct packed {
    duty_t    speed;
    heading_t heading;
  } cmd_stage_t;

  // cos(k degrees), k = 0..90, unsigned Q1.15 rounded to nearest
  localparam logic [COS_W-1:0] COS_Q15 [0:90] = '{
    16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688,
    16'd32643, 16'd32588, 16'd32524, 16'd32449, 16'd32365,
    16'd32270, 16'd32166, 16'd32052, 16'd31928, 16'd31795,
    16'd31651, 16'd31499, 16'd31336, 16'd31164, 16'd30983,
    16'd30792, 16'd30592, 16'd30382, 16'd30163, 16'd29935,
    16'd29698, 16'd29452, 16'd29197, 16'd28932, 16'd28660,
    16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166,
    16'd26842, 16'd26510, 16'd26170, 16'd25822, 16'd25466,
    16'd25102, 16'd24730, 16'd24351, 16'd23965, 16'd23571,
    16'd23170, 16'd22763, 16'd22348, 16'd21926, 16'd21498,
    16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261,
    16'd18795, 16'd18324, 16'd17847, 16'd17364, 16'd16877,
    16'd16384, 16'd15886, 16'd15384, 16'd14876, 16'd14365,
    16'd13848, 16'd13328, 16'd12803, 16'd12275, 16'd11743,
    16'd11207, 16'd10668, 16'd10126, 16'd9580,  16'd9032,
    16'd8481,  16'd7927,  16'd7371,  16'd6813,  16'd6252,
    16'd5690,  16'd5126,  16'd4560,  16'd3993,  16'd3425,
    16'd2856,  16'd2286,  16'd1715,  16'd1144,  16'd572,
    16'd0
  };

endpackage

// ----- src/hdd_cmd_if.sv -----
// Command channel: valid/ready handshake carrying speed and heading.
// Depends on hdd_pkg for the payload types.
interface hdd_cmd_if;
  import hdd_pkg::*;

  logic        valid;
  logic        ready;
  speed_in_t   speed_percent;
  heading_in_t heading_degrees;

  modport source (output valid, output speed_percent, output heading_degrees,
                  input ready);
  modport sink   (input valid, input speed_percent, input heading_degrees,
                  output ready);
endinterface

// ----- src/hdd_drive_if.sv -----
// Drive channel: valid/ready handshake carrying wheel duties and direction lines.
// Depends on hdd_pkg for the payload types.
interface hdd_drive_if;
  import hdd_pkg::*;

  logic  valid;
  logic  ready;
  duty_t left_duty;
  duty_t right_duty;
  logic  left_line_a;
  logic  left_line_b;
  logic  right_line_a;
  logic  right_line_b;

  modport source (output valid, output left_duty, output right_duty,
                  output left_line_a, output left_line_b,
                  output right_line_a, output right_line_b, input ready);
  modport sink   (input valid, input left_duty, input right_duty,
                  input left_line_a, input left_line_b,
                  input right_line_a, input right_line_b, output ready);
endinterface

// ----- src/heading_to_differential_drive.sv -----
// Top level: mixes a speed and heading command into two wheel duties.
// Depends on hdd_pkg, hdd_cmd_if, hdd_drive_if and the assertion macro header.
//
//   channel    | dir | payload                                   | transfer when
//   -----------+-----+-------------------------------------------+---------------------
//   in_cmd     | in  | speed_percent, heading_degrees            | valid && ready
//   out_drive  | out | left/right_duty, left/right_line_a/b      | valid && ready
//
// One command per cycle sustained while out_drive takes each result. A transfer registers
// the clamped speed and the heading reduced modulo 360 (one reciprocal multiply) in the
// command stage; the result register then loads the duties from the cosine lookup and
// speed multiply whenever it advances. rst_n (synchronous, active low)
// clears both valid flags only. A stall on out_drive holds the result register;
// ready drops only when both stages are full and out_drive is stalled.

`include "heading_to_differential_drive_defines.svh"

module heading_to_differential_drive #(
  parameter int COSINE_FRACTION_BITS = 15,
  parameter int SPEED_FRACTION_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  hdd_cmd_if.sink     in_cmd,
  hdd_drive_if.source out_drive
);
  import hdd_pkg::*;

  // Cosine magnitudes beyond the table's 15 fraction bits add only zeros,
  // which the product shift removes again; fold them to 15.
  localparam int CosBits =
    (COSINE_FRACTION_BITS > COS_TABLE_BITS) ? COS_TABLE_BITS : COSINE_FRACTION_BITS;
  localparam int SpeedMaxFull = PERCENT_FULL << SPEED_FRACTION_BITS;
  localparam duty_t SpeedMax =
    (SpeedMaxFull > SPEED_LIMIT) ? SPEED_W'(SPEED_LIMIT) : SPEED_W'(SpeedMaxFull);
  localparam int ProdW = COS_W + SPEED_W;

  // ---------------------------------------------------------------- control
  logic stg_v_r, stg_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_adv, stg_adv;

  assign out_adv = !out_v_r || out_drive.ready;
  assign stg_adv = !stg_v_r || out_adv;
  assign in_cmd.ready = stg_adv;

  assign stg_v_nxt = stg_adv ? in_cmd.valid : stg_v_r;
  assign out_v_nxt = out_adv ? stg_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // ------------------------------------------------------- command stage
  logic [HDG_EXT_W-1:0]           hdg_off;
  logic [2*HDG_EXT_W-1:0]         quo_prod;
  logic [QUO_W-1:0]               quo;
  logic [HDG_EXT_W-1:0]           rem_full;
  logic [REM_W-1:0]               rem;
  heading_t                       hdg_red;
  duty_t                          spd_clamp;
  cmd_stage_t                     stg_r, stg_nxt;

  always_comb begin
    // offset by whole turns so the value is positive, then floor-divide by 360
    hdg_off  = HDG_EXT_W'($unsigned(HDG_EXT_W'(in_cmd.heading_degrees)))
             + HDG_EXT_W'(HDG_OFFSET);
    quo_prod = (2*HDG_EXT_W)'(hdg_off) * (2*HDG_EXT_W)'(RECIP);
    quo      = quo_prod[RECIP_SHIFT +: QUO_W];
    rem_full = hdg_off - HDG_EXT_W'(HDG_EXT_W'(quo) * HDG_EXT_W'(DEG_FULL));
    rem      = rem_full[REM_W-1:0];
    // the reciprocal underestimates by at most one turn
    if (rem >= REM_W'(DEG_FULL)) begin
      hdg_red = HEADING_W'(rem - REM_W'(DEG_FULL));
    end else begin
      hdg_red = HEADING_W'(rem);
    end

    if (in_cmd.speed_percent[15]) begin
      spd_clamp = '0;
    end else if (in_cmd.speed_percent[SPEED_W-1:0] > SpeedMax) begin
      spd_clamp = SpeedMax;
    end else begin
      spd_clamp = in_cmd.speed_percent[SPEED_W-1:0];
    end

    stg_nxt.speed   = spd_clamp;
    stg_nxt.heading = hdg_red;
  end

  // payload: load whenever the stage can advance (in_cmd.ready high), hold otherwise
  always_ff @(posedge clk) begin
    if (stg_adv) begin
      stg_r <= stg_nxt;
    end
  end

  // ------------------------------------------------------- mixing stage
  logic [HEADING_W-1:0] dbl_angle;
  logic [COS_IDX_W-1:0] cos_idx;
  logic                 cos_neg;
  logic [COS_W-1:0]     cos_mag;
  logic [ProdW-1:0]     prod_full;
  duty_t                prod_mag;
  logic                 prod_zero, spd_zero;
  logic                 prod_fwd, nprod_fwd;
  quad_t                quad;

  duty_t left_duty_r,  left_duty_nxt;
  duty_t right_duty_r, right_duty_nxt;
  logic  left_fwd_r,   left_fwd_nxt;
  logic  right_fwd_r,  right_fwd_nxt;

  always_comb begin
    // angle of cos(2*heading), reduced to 0..359
    if (stg_r.heading < HEADING_W'(DEG_HALF)) begin
      dbl_angle = HEADING_W'({stg_r.heading, 1'b0});
    end else begin
      dbl_angle = HEADING_W'({stg_r.heading, 1'b0} - 10'(DEG_FULL));
    end

    // fold onto the first quadrant; the sign travels apart
    if (dbl_angle <= HEADING_W'(DEG_QUARTER)) begin
      cos_idx = COS_IDX_W'(dbl_angle);
      cos_neg = 1'b0;
    end else if (dbl_angle <= HEADING_W'(DEG_HALF)) begin
      cos_idx = COS_IDX_W'(HEADING_W'(DEG_HALF) - dbl_angle);
      cos_neg = 1'b1;
    end else if (dbl_angle <= HEADING_W'(DEG_3QUARTER)) begin
      cos_idx = COS_IDX_W'(dbl_angle - HEADING_W'(DEG_HALF));
      cos_neg = 1'b1;
    end else begin
      cos_idx = COS_IDX_W'(HEADING_W'(DEG_FULL) - dbl_angle);
      cos_neg = 1'b0;
    end

    cos_mag   = COS_Q15[cos_idx] >> (COS_TABLE_BITS - CosBits);
    prod_full = ProdW'(cos_mag) * ProdW'(stg_r.speed);
    // truncate toward zero; the magnitude never exceeds the speed
    prod_mag  = prod_full[CosBits +: SPEED_W];

    prod_zero = (prod_mag == '0);
    spd_zero  = (stg_r.speed == '0);
    prod_fwd  = !cos_neg || prod_zero;   // signed product >= 0
    nprod_fwd = cos_neg || prod_zero;    // negated product >= 0

    if (stg_r.heading < HEADING_W'(DEG_QUARTER)) begin
      quad = QUAD_FWD_RIGHT;
    end else if (stg_r.heading < HEADING_W'(DEG_HALF)) begin
      quad = QUAD_REV_RIGHT;
    end else if (stg_r.heading < HEADING_W'(DEG_3QUARTER)) begin
      quad = QUAD_REV_LEFT;
    end else begin
      quad = QUAD_FWD_LEFT;
    end
  end

  always_comb begin
    case (quad)
      QUAD_FWD_RIGHT: begin
        left_duty_nxt  = stg_r.speed;
        right_duty_nxt = prod_mag;
        left_fwd_nxt   = 1'b1;
        right_fwd_nxt  = prod_fwd;
      end
      QUAD_REV_RIGHT: begin
        left_duty_nxt  = prod_mag;
        right_duty_nxt = stg_r.speed;
        left_fwd_nxt   = nprod_fwd;
        right_fwd_nxt  = spd_zero;
      end
      QUAD_REV_LEFT: begin
        left_duty_nxt  = stg_r.speed;
        right_duty_nxt = prod_mag;
        left_fwd_nxt   = spd_zero;
        right_fwd_nxt  = nprod_fwd;
      end
      QUAD_FWD_LEFT: begin
        left_duty_nxt  = prod_mag;
        right_duty_nxt = stg_r.speed;
        left_fwd_nxt   = prod_fwd;
        right_fwd_nxt  = 1'b1;
      end
      default: begin
        left_duty_nxt  = '0;
        right_duty_nxt = '0;
        left_fwd_nxt   = 1'b1;
        right_fwd_nxt  = 1'b1;
      end
    endcase
  end

  // result register: advance when empty or taken, hold under stall
  always_ff @(posedge clk) begin
    if (out_adv) begin
      left_duty_r  <= left_duty_nxt;
      right_duty_r <= right_duty_nxt;
      left_fwd_r   <= left_fwd_nxt;
      right_fwd_r  <= right_fwd_nxt;
    end
  end

  assign out_drive.valid        = out_v_r;
  assign out_drive.left_duty    = left_duty_r;
  assign out_drive.right_duty   = right_duty_r;
  assign out_drive.left_line_a  = left_fwd_r;
  assign out_drive.left_line_b  = ~left_fwd_r;
  assign out_drive.right_line_a = right_fwd_r;
  assign out_drive.right_line_b = ~right_fwd_r;

  // ------------------------------------------------------- assertions
  `HDD_ASSERT(a_heading_reduced, stg_v_r |-> (stg_r.heading < HEADING_W'(DEG_FULL)), "heading not reduced below 360")
  `HDD_ASSERT(a_stage_holds, (stg_v_r && !out_adv) |=> (stg_v_r && $stable(stg_r)), "command stage changed under stall")
  `HDD_ASSERT_NEVER(a_duty_bound, out_v_r && ((left_duty_r > SpeedMax) || (right_duty_r > SpeedMax)), "duty above speed limit")
  `HDD_ASSERT_NEVER(a_zero_forward, out_v_r && (((left_duty_r == '0) && !left_fwd_r) || ((right_duty_r == '0) && !right_fwd_r)), "zero duty reported reverse")

endmodule
